/* hw/rtl/dictionary_rle_encoder_macros.svh */
// Assertion macros used by the encoder.
`ifndef DICTIONARY_RLE_ENCODER_MACROS_SVH
`define DICTIONARY_RLE_ENCODER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define DRE_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("%m: check failed");
// Condition that holds on every rising clock edge outside reset.
`define DRE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: check failed");
`endif

/* hw/rtl/dre_pkg.sv */
`timescale 1ns / 1ps
package dre_pkg;
    localparam int DictDepth = 1024;
    localparam int MaxKeyBytes = 16;
    localparam int IdxW = $clog2(DictDepth);
    localparam int CntW = $clog2(DictDepth + 1);
    localparam int PosW = $clog2(MaxKeyBytes);
    localparam int LenW = $clog2(MaxKeyBytes + 1);
    localparam int StoreAw = IdxW + PosW;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_ROW = 2'd1;
    localparam logic [1:0] KIND_BLOCK = 2'd2;
    localparam logic [1:0] KIND_RSVD = 2'd3;

    localparam logic [1:0] OUT_INDEX = 2'd0;
    localparam logic [1:0] OUT_RUN = 2'd1;
    localparam logic [1:0] OUT_SUMMARY = 2'd2;
    localparam logic [1:0] OUT_ERROR = 2'd3;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_LONG = 2'd1;
    localparam logic [1:0] ERR_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]      out_kind;
        logic [IdxW-1:0] dict_index;
        logic            new_entry;
        logic [31:0]     run_length;
        logic [CntW-1:0] dict_size;
        logic [2:0]      idx_bytes;
        logic [1:0]      error_code;
        logic            last;
    } t_result;

    function automatic logic [2:0] width_for(input logic [CntW-1:0] n);
        if (32'(n) <= 32'd255) return 3'd1;
        else if (32'(n) <= 32'd65535) return 3'd2;
        else return 3'd4;
    endfunction
endpackage

/* hw/rtl/dictionary_rle_encoder.sv */
`timescale 1ns / 1ps
// Dictionary encoder with optional run-length coding of the index stream.
// Input channel: i_valid/o_stall carrying i_kind and i_key_byte. Output
// channel: o_valid/i_stall carrying one result per transfer; o_last marks
// the last result caused by an input item. The rle_mode register is written
// through i_cfg_valid/o_cfg_ready; the user must write it only while the
// block is idle, which the block itself does not enforce. A key byte or an
// ignored item is taken without leaving the idle state. An end of row walks
// the stored entries in insertion order, reading lengths and key bytes from
// the key store with registered reads: an entry is checked by length first,
// then byte by byte, and left at the first mismatch. An unseen key is then
// copied into the next free entry, bytes first and length last. When a run
// record closes first, the index result follows once that record is taken.
// An end of block registers its first result at the transfer edge and, when
// a run is open, a second one in the cycle after the first is taken; the
// store is emptied by resetting the entry count, so no clearing pass is needed.
// Results are held in an output register; while the receiver stalls, the
// block holds its result and takes no further input. Reset clears the
// entry count, the open run, the error and rle_mode.
module dictionary_rle_encoder (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_kind,
    input  logic [7:0]               i_key_byte,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_out_kind,
    output logic [dre_pkg::IdxW-1:0] o_dict_index,
    output logic                     o_new_entry,
    output logic [31:0]              o_run_length,
    output logic [dre_pkg::CntW-1:0] o_entry_count,
    output logic [2:0]               o_index_width,
    output logic [1:0]               o_error_code,
    output logic                     o_last
);
    import dre_pkg::*;
    `include "dictionary_rle_encoder_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LEN = 3'd1;
    localparam logic [2:0] S_CMP = 3'd2;
    localparam logic [2:0] S_COPY = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_EMIT2 = 3'd5;

    logic [2:0]      r_state, n_state;
    logic [7:0]      r_kbuf [MaxKeyBytes];
    logic [LenW-1:0] r_klen, n_klen;
    logic [CntW-1:0] r_count, n_count;
    logic [IdxW-1:0] r_run_index, n_run_index;
    logic [31:0]     r_run_count, n_run_count;
    logic [1:0]      r_err, n_err;
    logic            r_rle;
    logic [CntW-1:0] r_scan, n_scan;
    logic [LenW-1:0] r_pos, n_pos;
    logic            r_out_valid, n_out_valid;
    t_result         r_out, n_out;
    t_result         r_pend, n_pend;
    logic            r_fresh, n_fresh;

    logic [7:0]      mem_rdata;
    logic [LenW-1:0] mem_len;
    logic            we;
    logic [StoreAw-1:0] waddr, raddr;
    logic            len_we;
    logic            kbuf_we;

    logic            out_free;
    logic            in_take;
    logic [IdxW-1:0] scan_idx;
    logic [IdxW-1:0] count_idx;
    logic [PosW-1:0] pos_idx;

    assign scan_idx = r_scan[IdxW-1:0];
    assign count_idx = r_count[IdxW-1:0];
    assign pos_idx = r_pos[PosW-1:0];
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall = (r_state != S_IDLE) || !out_free;
    assign in_take = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Key store addressing: compare reads and copy writes.
    assign raddr = {scan_idx, pos_idx};
    assign waddr = {count_idx, pos_idx};
    assign we = (r_state == S_COPY) && (r_pos < r_klen);
    assign len_we = (r_state == S_COPY) && (r_pos == r_klen);

    dre_key_store u_store (
        .i_clk       (i_clk),
        .i_we        (we),
        .i_waddr     (waddr),
        .i_wdata     (r_kbuf[pos_idx]),
        .i_len_we    (len_we),
        .i_len_waddr (count_idx),
        .i_len_wdata (r_klen),
        .i_raddr     (raddr),
        .i_len_raddr (scan_idx),
        .o_rdata     (mem_rdata),
        .o_len_rdata (mem_len)
    );

    function automatic t_result mk(input logic [1:0] k, input logic [IdxW-1:0] idx,
                                   input logic fr, input logic [31:0] run,
                                   input logic [CntW-1:0] cnt, input logic [1:0] e,
                                   input logic l);
        t_result res;
        res.out_kind = k;
        res.dict_index = idx;
        res.new_entry = fr;
        res.run_length = run;
        res.dict_size = cnt;
        res.idx_bytes = width_for(cnt);
        res.error_code = e;
        res.last = l;
        return res;
    endfunction

    // Row sequencer and result generation.
    always_comb begin
        n_state = r_state;
        n_klen = r_klen;
        n_count = r_count;
        n_run_index = r_run_index;
        n_run_count = r_run_count;
        n_err = r_err;
        n_scan = r_scan;
        n_pos = r_pos;
        n_out_valid = r_out_valid && i_stall;
        n_out = r_out;
        n_pend = r_pend;
        n_fresh = r_fresh;
        kbuf_we = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    unique case (i_kind)
                        KIND_BYTE: begin
                            if (r_err == ERR_NONE) begin
                                if (r_klen >= LenW'(MaxKeyBytes)) begin
                                    n_err = ERR_LONG;
                                    n_out = mk(OUT_ERROR, '0, 1'b0, '0, r_count,
                                               ERR_LONG, 1'b1);
                                    n_out_valid = 1'b1;
                                end else begin
                                    kbuf_we = 1'b1;
                                    n_klen = r_klen + 1'b1;
                                end
                            end
                        end
                        KIND_ROW: begin
                            if (r_err == ERR_NONE) begin
                                n_scan = '0;
                                n_pos = '0;
                                n_state = S_LEN;
                            end
                        end
                        KIND_BLOCK: begin
                            if (r_err == ERR_NONE && r_run_count != 32'd0) begin
                                n_out = mk(OUT_RUN, r_run_index, 1'b0, r_run_count,
                                           r_count, ERR_NONE, 1'b0);
                                n_pend = mk(OUT_SUMMARY, '0, 1'b0, '0, r_count,
                                            ERR_NONE, 1'b1);
                                n_state = S_EMIT2;
                            end else begin
                                n_out = mk(OUT_SUMMARY, '0, 1'b0, '0, r_count,
                                           r_err, 1'b1);
                            end
                            n_out_valid = 1'b1;
                            n_klen = '0;
                            n_count = '0;
                            n_run_index = '0;
                            n_run_count = '0;
                            n_err = ERR_NONE;
                        end
                        default: ;
                    endcase
                end
            end
            S_LEN: begin
                // Request the length of the entry under scan, or decide unseen or full.
                if (r_scan >= r_count) begin
                    if (r_count >= CntW'(DictDepth)) begin
                        n_err = ERR_FULL;
                        n_klen = '0;
                        n_out = mk(OUT_ERROR, '0, 1'b0, '0, r_count, ERR_FULL, 1'b1);
                        n_out_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_pos = '0;
                        n_state = S_COPY;
                    end
                end else begin
                    n_pos = '0;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // Data read at r_pos-1 arrives now; the first cycle checks the length.
                if (r_pos == '0) begin
                    if (mem_len != r_klen) begin
                        n_scan = r_scan + 1'b1;
                        n_state = S_LEN;
                    end else if (r_klen == '0) begin
                        n_state = S_EMIT;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end else if (mem_rdata != r_kbuf[PosW'(r_pos - 1'b1)]) begin
                    n_scan = r_scan + 1'b1;
                    n_pos = '0;
                    n_state = S_LEN;
                end else if (r_pos == r_klen) begin
                    n_state = S_EMIT;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            S_COPY: begin
                // Copy the row into the next free entry, length last.
                if (r_pos == r_klen) begin
                    n_scan = r_count;
                    n_count = r_count + 1'b1;
                    n_fresh = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            S_EMIT: begin
                // Row done; its index is r_scan.
                if (out_free) begin
                    n_klen = '0;
                    n_fresh = 1'b0;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                    n_out = mk(OUT_INDEX, scan_idx, r_fresh, '0, r_count, ERR_NONE, 1'b1);
                    if (r_rle) begin
                        if (r_run_count == 32'd0) begin
                            n_run_index = scan_idx;
                            n_run_count = 32'd1;
                        end else if (r_run_index == scan_idx) begin
                            if (r_run_count != 32'hFFFF_FFFF)
                                n_run_count = r_run_count + 1'b1;
                        end else begin
                            n_out = mk(OUT_RUN, r_run_index, 1'b0, r_run_count, r_count,
                                       ERR_NONE, 1'b0);
                            n_pend = mk(OUT_INDEX, scan_idx, r_fresh, '0, r_count,
                                        ERR_NONE, 1'b1);
                            n_run_index = scan_idx;
                            n_run_count = 32'd1;
                            n_state = S_EMIT2;
                        end
                    end
                end
            end
            S_EMIT2: begin
                // Second result of the item once the first one is taken.
                if (out_free) begin
                    n_out = r_pend;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_klen <= '0;
            r_count <= '0;
            r_run_index <= '0;
            r_run_count <= '0;
            r_err <= ERR_NONE;
            r_rle <= 1'b0;
            r_out_valid <= 1'b0;
            r_fresh <= 1'b0;
            r_scan <= '0;
            r_pos <= '0;
        end else begin
            r_state <= n_state;
            r_klen <= n_klen;
            r_count <= n_count;
            r_run_index <= n_run_index;
            r_run_count <= n_run_count;
            r_err <= n_err;
            r_out_valid <= n_out_valid;
            r_fresh <= n_fresh;
            r_scan <= n_scan;
            r_pos <= n_pos;
            if (i_cfg_valid) r_rle <= i_cfg_data;
        end
    end

    // Result registers are only read while their valid is set.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_pend <= n_pend;
    end

    // Row buffer write.
    always_ff @(posedge i_clk) begin
        if (kbuf_we) r_kbuf[r_klen[PosW-1:0]] <= i_key_byte;
    end

    assign o_valid = r_out_valid;
    assign o_out_kind = r_out.out_kind;
    assign o_dict_index = r_out.dict_index;
    assign o_new_entry = r_out.new_entry;
    assign o_run_length = r_out.run_length;
    assign o_entry_count = r_out.dict_size;
    assign o_index_width = r_out.idx_bytes;
    assign o_error_code = r_out.error_code;
    assign o_last = r_out.last;

    `DRE_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `DRE_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CntW'(DictDepth))
    `DRE_ASSERT_ALWAYS(a_klen_range, i_clk, i_rst_n, r_klen <= LenW'(MaxKeyBytes))
    `DRE_ASSERT_IMP(a_hold, i_clk, i_rst_n, o_valid && i_stall, ##1 o_valid && $stable(o_out_kind))
endmodule

/* hw/rtl/dre_key_store.sv */
`timescale 1ns / 1ps
// Dictionary key bytes and key lengths, one read port each with a registered read.
module dre_key_store (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [dre_pkg::StoreAw-1:0] i_waddr,
    input  logic [7:0]                 i_wdata,
    input  logic                       i_len_we,
    input  logic [dre_pkg::IdxW-1:0]   i_len_waddr,
    input  logic [dre_pkg::LenW-1:0]   i_len_wdata,
    input  logic [dre_pkg::StoreAw-1:0] i_raddr,
    input  logic [dre_pkg::IdxW-1:0]   i_len_raddr,
    output logic [7:0]                 o_rdata,
    output logic [dre_pkg::LenW-1:0]   o_len_rdata
);
    import dre_pkg::*;
    logic [7:0]      r_bytes [DictDepth*MaxKeyBytes];
    logic [LenW-1:0] r_lens [DictDepth];

    // Byte store.
    always_ff @(posedge i_clk) begin
        if (i_we) r_bytes[i_waddr] <= i_wdata;
        o_rdata <= r_bytes[i_raddr];
    end

    // Length store.
    always_ff @(posedge i_clk) begin
        if (i_len_we) r_lens[i_len_waddr] <= i_len_wdata;
        o_len_rdata <= r_lens[i_len_raddr];
    end
endmodule
